[hdl/complex_arith_unit_core_assert.svh]
// ----------------------------------------------------------------------------
// assertion macros for the complex arithmetic unit
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_CORE_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CAU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent a fixed number of cycles later
`define CAU_ASSERT_DELAY(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("assertion failed");

`endif

[hdl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// types, codes and widths shared by the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int WIDTH     = 16;
  localparam int FRAC_BITS = 8;
  localparam int PROD_W    = 2 * WIDTH;          // one product
  localparam int SUM_W     = 2 * WIDTH + 1;      // sum of two products
  localparam int DEN_W     = 2 * WIDTH;          // c*c + d*d, unsigned
  localparam int MAG_W     = DEN_W + FRAC_BITS;  // |num| << FRAC_BITS
  localparam int Q_W       = WIDTH;              // quotient bits computed

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (WIDTH - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(1 << (WIDTH - 1));

  typedef struct packed {
    logic [2:0]              op;
    logic signed [WIDTH-1:0] a_real;
    logic signed [WIDTH-1:0] a_imag;
    logic signed [WIDTH-1:0] b_real;
    logic signed [WIDTH-1:0] b_imag;
  } in_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] res_real;
    logic signed [WIDTH-1:0] res_imag;
    logic [1:0]              status;
  } out_t;

  // front end results after the product sums
  typedef struct packed {
    logic [2:0]              op;
    logic signed [WIDTH:0]   simp_re;
    logic signed [WIDTH:0]   simp_im;
    logic signed [SUM_W-1:0] mul_re;
    logic signed [SUM_W-1:0] mul_im;
    logic signed [SUM_W-1:0] num_re;
    logic signed [SUM_W-1:0] num_im;
    logic [DEN_W-1:0]        den;
  } mid_t;

  // one divider lane in flight
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   low;
    logic [Q_W-1:0]   quo;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             ovf;
  } div_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] v;
    logic                    sat;
  } sat_t;

  function automatic sat_t sat_val(logic signed [SUM_W-1:0] x);
    sat_t r;
    if (x > SAT_MAX) begin
      r.v = SAT_MAX[WIDTH-1:0];
      r.sat = 1'b1;
    end else if (x < SAT_MIN) begin
      r.v = SAT_MIN[WIDTH-1:0];
      r.sat = 1'b1;
    end else begin
      r.v = x[WIDTH-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

[hdl/cau_mul.sv]
// ----------------------------------------------------------------------------
// cau_mul
// input register, six products, then sums of products and the denominator
// ----------------------------------------------------------------------------
module cau_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  cau_pkg::in_t  in_data,
  output logic          mid_valid,
  output cau_pkg::mid_t mid
);

  cau_pkg::in_t in_r;
  logic         v1_r, v2_r, v3_r;

  logic [2:0] op2_r;
  logic signed [cau_pkg::WIDTH:0] sre2_r, sim2_r;
  logic signed [cau_pkg::PROD_W-1:0] ac_r, bd_r, bc_r, ad_r, cc_r, dd_r;
  logic signed [cau_pkg::WIDTH:0] sre_nxt, sim_nxt;
  cau_pkg::mid_t mid_r, mid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_comb begin
    sre_nxt = '0;
    sim_nxt = '0;
    case (in_r.op)
      cau_pkg::OP_ADD: begin
        sre_nxt = in_r.a_real + in_r.b_real;
        sim_nxt = in_r.a_imag + in_r.b_imag;
      end
      cau_pkg::OP_SUB: begin
        sre_nxt = in_r.a_real - in_r.b_real;
        sim_nxt = in_r.a_imag - in_r.b_imag;
      end
      cau_pkg::OP_CONJ: begin
        sre_nxt = in_r.a_real;
        sim_nxt = -(cau_pkg::WIDTH+1)'(in_r.a_imag);
      end
      default: begin
        sre_nxt = '0;
        sim_nxt = '0;
      end
    endcase
  end

  always_comb begin
    mid_nxt.op      = op2_r;
    mid_nxt.simp_re = sre2_r;
    mid_nxt.simp_im = sim2_r;
    mid_nxt.mul_re  = cau_pkg::SUM_W'(ac_r) - cau_pkg::SUM_W'(bd_r);
    mid_nxt.mul_im  = cau_pkg::SUM_W'(bc_r) + cau_pkg::SUM_W'(ad_r);
    mid_nxt.num_re  = cau_pkg::SUM_W'(ac_r) + cau_pkg::SUM_W'(bd_r);
    mid_nxt.num_im  = cau_pkg::SUM_W'(bc_r) - cau_pkg::SUM_W'(ad_r);
    mid_nxt.den     = cau_pkg::DEN_W'(cc_r) + cau_pkg::DEN_W'(dd_r);
  end

  always_ff @(posedge clk) begin
    in_r   <= in_data;
    op2_r  <= in_r.op;
    sre2_r <= sre_nxt;
    sim2_r <= sim_nxt;
    ac_r   <= in_r.a_real * in_r.b_real;
    bd_r   <= in_r.a_imag * in_r.b_imag;
    bc_r   <= in_r.a_imag * in_r.b_real;
    ad_r   <= in_r.a_real * in_r.b_imag;
    cc_r   <= in_r.b_real * in_r.b_real;
    dd_r   <= in_r.b_imag * in_r.b_imag;
    mid_r  <= mid_nxt;
  end

  assign mid_valid = v3_r;
  assign mid       = mid_r;

endmodule

[hdl/cau_div.sv]
// ----------------------------------------------------------------------------
// cau_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module cau_div (
  input  logic          clk,
  input  cau_pkg::div_t d_in,
  output cau_pkg::div_t d_out
);

  cau_pkg::div_t st_r [cau_pkg::Q_W];

  function automatic cau_pkg::div_t div_step(cau_pkg::div_t x);
    cau_pkg::div_t        r;
    logic [cau_pkg::DEN_W:0] r2;
    r  = x;
    r2 = {x.rem, x.low[cau_pkg::Q_W-1]};
    r.low = {x.low[cau_pkg::Q_W-2:0], 1'b0};
    if (r2 >= {1'b0, x.den}) begin
      r.rem = cau_pkg::DEN_W'(r2 - {1'b0, x.den});
      r.quo = {x.quo[cau_pkg::Q_W-2:0], 1'b1};
    end else begin
      r.rem = r2[cau_pkg::DEN_W-1:0];
      r.quo = {x.quo[cau_pkg::Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    st_r[0] <= div_step(d_in);
  end

  for (genvar k = 1; k < cau_pkg::Q_W; k++) begin : g_stage
    always_ff @(posedge clk) begin
      st_r[k] <= div_step(st_r[k-1]);
    end
  end

  assign d_out = st_r[cau_pkg::Q_W-1];

endmodule

[hdl/complex_arith_unit_core.sv]
// throughput: one transaction per cycle, busy stays low
// the 16 stage quotient pipeline sets the latency; multipliers take three stages
// reset: synchronous active-low rst_n clears all valid bits, no result is lost
// after reset since the receiver cannot stall
// ----------------------------------------------------------------------------
// complex_arith_unit_core
// complex add, subtract, multiply, divide and conjugate on Q8.8 operands
// ----------------------------------------------------------------------------
module complex_arith_unit_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  cau_pkg::in_t  in_data,
  output logic          busy,
  output logic          out_valid,
  output cau_pkg::out_t out_data
);

  `include "complex_arith_unit_core_assert.svh"

  localparam int LATENCY = cau_pkg::Q_W + 5;

  typedef struct packed {
    logic          is_div;
    logic          div0;
    cau_pkg::out_t res;
  } side_t;

  logic          mid_valid;
  cau_pkg::mid_t mid;

  cau_pkg::div_t dre_r, dim_r, dre_o, dim_o;
  side_t         side_nxt;
  side_t         side_r [cau_pkg::Q_W+1];
  logic          sv_r   [cau_pkg::Q_W+1];
  cau_pkg::sat_t sre, sim, qre, qim;
  cau_pkg::out_t out_nxt;
  logic          out_valid_r;
  cau_pkg::out_t out_data_r;

  function automatic cau_pkg::div_t div_prep(logic signed [cau_pkg::SUM_W-1:0] num,
                                             logic [cau_pkg::DEN_W-1:0] den);
    cau_pkg::div_t            r;
    logic [cau_pkg::SUM_W-1:0] mag;
    logic [cau_pkg::MAG_W-1:0] full;
    mag  = num[cau_pkg::SUM_W-1] ? cau_pkg::SUM_W'(-num) : num;
    full = {mag[cau_pkg::DEN_W-1:0], {cau_pkg::FRAC_BITS{1'b0}}};
    r.neg = num[cau_pkg::SUM_W-1];
    // quotient would not fit the computed bits
    r.ovf = {{cau_pkg::Q_W{1'b0}}, full} >= {{cau_pkg::FRAC_BITS{1'b0}}, den,
                                             {cau_pkg::Q_W{1'b0}}};
    r.rem = cau_pkg::DEN_W'(full[cau_pkg::MAG_W-1:cau_pkg::Q_W]);
    r.low = full[cau_pkg::Q_W-1:0];
    r.quo = '0;
    r.den = den;
    return r;
  endfunction

  function automatic cau_pkg::sat_t div_fin(cau_pkg::div_t x);
    cau_pkg::sat_t            r;
    logic [cau_pkg::Q_W:0]    q;
    q = {1'b0, x.quo};
    if (x.neg) begin
      if (x.ovf || q > (cau_pkg::Q_W+1)'(1 << (cau_pkg::WIDTH - 1))) begin
        r.v   = cau_pkg::SAT_MIN[cau_pkg::WIDTH-1:0];
        r.sat = 1'b1;
      end else begin
        r.v   = cau_pkg::WIDTH'(-q);
        r.sat = 1'b0;
      end
    end else begin
      if (x.ovf || q > (cau_pkg::Q_W+1)'((1 << (cau_pkg::WIDTH - 1)) - 1)) begin
        r.v   = cau_pkg::SAT_MAX[cau_pkg::WIDTH-1:0];
        r.sat = 1'b1;
      end else begin
        r.v   = x.quo;
        r.sat = 1'b0;
      end
    end
    return r;
  endfunction

  assign busy = 1'b0;

  cau_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_data   (in_data),
    .mid_valid (mid_valid),
    .mid       (mid)
  );

  // results that need no division
  always_comb begin
    sre = '0;
    sim = '0;
    side_nxt = '0;
    case (mid.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_CONJ: begin
        sre = cau_pkg::sat_val(cau_pkg::SUM_W'(mid.simp_re));
        sim = cau_pkg::sat_val(cau_pkg::SUM_W'(mid.simp_im));
      end
      cau_pkg::OP_MUL: begin
        sre = cau_pkg::sat_val(mid.mul_re >>> cau_pkg::FRAC_BITS);
        sim = cau_pkg::sat_val(mid.mul_im >>> cau_pkg::FRAC_BITS);
      end
      cau_pkg::OP_DIV: begin
        side_nxt.is_div = 1'b1;
        side_nxt.div0   = (mid.den == '0);
      end
      default: begin
        sre = '0;
        sim = '0;
      end
    endcase
    side_nxt.res.res_real = sre.v;
    side_nxt.res.res_imag = sim.v;
    side_nxt.res.status   = (sre.sat || sim.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    dre_r     <= div_prep(mid.num_re, mid.den);
    dim_r     <= div_prep(mid.num_im, mid.den);
    side_r[0] <= side_nxt;
  end

  // sideband travels next to the quotient pipeline
  for (genvar k = 1; k <= cau_pkg::Q_W; k++) begin : g_side
    always_ff @(posedge clk) begin
      side_r[k] <= side_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= cau_pkg::Q_W; i++) begin
        sv_r[i] <= 1'b0;
      end
    end else begin
      sv_r[0] <= mid_valid;
      for (int i = 1; i <= cau_pkg::Q_W; i++) begin
        sv_r[i] <= sv_r[i-1];
      end
    end
  end

  cau_div u_div_re (
    .clk   (clk),
    .d_in  (dre_r),
    .d_out (dre_o)
  );

  cau_div u_div_im (
    .clk   (clk),
    .d_in  (dim_r),
    .d_out (dim_o)
  );

  always_comb begin
    qre = div_fin(dre_o);
    qim = div_fin(dim_o);
    out_nxt = side_r[cau_pkg::Q_W].res;
    if (side_r[cau_pkg::Q_W].is_div) begin
      if (side_r[cau_pkg::Q_W].div0) begin
        out_nxt.res_real = '0;
        out_nxt.res_imag = '0;
        out_nxt.status   = cau_pkg::ST_DIV0;
      end else begin
        out_nxt.res_real = qre.v;
        out_nxt.res_imag = qim.v;
        out_nxt.status   = (qre.sat || qim.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sv_r[cau_pkg::Q_W];
    end
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CAU_ASSERT_DELAY(a_latency, start, LATENCY, out_valid)
  `CAU_ASSERT_SAME(a_div0_zero, out_valid && out_data.status == cau_pkg::ST_DIV0,
                   out_data.res_real == '0 && out_data.res_imag == '0)
  `CAU_ASSERT_SAME(a_sat_rail, out_valid && out_data.status == cau_pkg::ST_SAT,
                   out_data.res_real == cau_pkg::SAT_MAX[cau_pkg::WIDTH-1:0] ||
                   out_data.res_real == cau_pkg::SAT_MIN[cau_pkg::WIDTH-1:0] ||
                   out_data.res_imag == cau_pkg::SAT_MAX[cau_pkg::WIDTH-1:0] ||
                   out_data.res_imag == cau_pkg::SAT_MIN[cau_pkg::WIDTH-1:0])

endmodule

[tb/complex_arith_unit_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit_core_tb
// drives add, subtract, multiply, divide, conjugate and unused opcodes with
// directed corner operands and random traffic with random gaps, predicts each
// result with a wide-integer model and compares it field by field in order
// ----------------------------------------------------------------------------
module complex_arith_unit_core_tb;

  localparam int LATENCY = 21;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  cau_pkg::in_t  in_data = '0;
  logic          busy;
  logic          out_valid;
  cau_pkg::out_t out_data;

  cau_pkg::out_t expected_q[$];
  int            errors = 0;

  complex_arith_unit_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data),
    .busy(busy), .out_valid(out_valid), .out_data(out_data)
  );

  always #1 clk = ~clk;

  function automatic logic signed [cau_pkg::WIDTH-1:0] clamp(longint v, ref bit hit);
    if (v > 32767) begin
      hit = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      hit = 1'b1;
      return 16'sh8000;
    end
    return v[cau_pkg::WIDTH-1:0];
  endfunction

  // truncating signed division of a wide numerator
  function automatic longint quot(longint num, longint den);
    longint m;
    m = (num < 0) ? -num : num;
    m = m / den;
    return (num < 0) ? -m : m;
  endfunction

  function automatic cau_pkg::out_t complex_result(cau_pkg::in_t t);
    cau_pkg::out_t r;
    bit            hit;
    longint        a, b, c, d, re, im, den;
    hit = 1'b0;
    a = t.a_real; b = t.a_imag; c = t.b_real; d = t.b_imag;
    re = 0; im = 0;
    case (t.op)
      cau_pkg::OP_ADD: begin re = a + c; im = b + d; end
      cau_pkg::OP_SUB: begin re = a - c; im = b - d; end
      cau_pkg::OP_MUL: begin
        re = (a * c - b * d) >>> cau_pkg::FRAC_BITS;
        im = (b * c + a * d) >>> cau_pkg::FRAC_BITS;
      end
      cau_pkg::OP_DIV: begin
        den = c * c + d * d;
        if (den == 0) begin
          r.res_real = '0;
          r.res_imag = '0;
          r.status = cau_pkg::ST_DIV0;
          return r;
        end
        re = quot((a * c + b * d) <<< cau_pkg::FRAC_BITS, den);
        im = quot((b * c - a * d) <<< cau_pkg::FRAC_BITS, den);
      end
      cau_pkg::OP_CONJ: begin re = a; im = -b; end
      default: ;
    endcase
    r.res_real = clamp(re, hit);
    r.res_imag = clamp(im, hit);
    r.status = hit ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    return r;
  endfunction

  task automatic send_item(cau_pkg::in_t t, int gap);
    in_data <= t;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_q.push_back(complex_result(t));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int rand_gap(bit bursty);
    int p;
    if (bursty) return 0;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [cau_pkg::WIDTH-1:0] rand_operand();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 1023)) - 512);
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transaction %p", out_data);
        errors++;
      end else begin
        cau_pkg::out_t e;
        e = expected_q.pop_front();
        if (out_data.res_real !== e.res_real) begin
          $error("res_real exp %0d got %0d", e.res_real, out_data.res_real);
          errors++;
        end
        if (out_data.res_imag !== e.res_imag) begin
          $error("res_imag exp %0d got %0d", e.res_imag, out_data.res_imag);
          errors++;
        end
        if (out_data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data.status);
          errors++;
        end
      end
    end
  end

  task automatic mk(output cau_pkg::in_t t, input logic [2:0] op, input int ar,
                    input int ai, input int br, input int bi);
    t.op = op;
    t.a_real = ar[15:0]; t.a_imag = ai[15:0]; t.b_real = br[15:0]; t.b_imag = bi[15:0];
  endtask

  task automatic test_directed();
    cau_pkg::in_t t;
    for (int op = 0; op < 8; op++) begin
      mk(t, 3'(op), 32767, -32768, 32767, -32768); send_item(t, 0);
      mk(t, 3'(op), -32768, 32767, -32768, 32767); send_item(t, 1);
      mk(t, 3'(op), 384, -128, 256, 512); send_item(t, 0);
    end
    mk(t, cau_pkg::OP_DIV, 1000, -2000, 0, 0); send_item(t, 0);
    mk(t, cau_pkg::OP_CONJ, 5, -32768, 9, 9); send_item(t, 2);
    mk(t, cau_pkg::OP_DIV, 32767, 32767, 1, 0); send_item(t, 0);
    mk(t, cau_pkg::OP_DIV, -32768, -32768, 0, -1); send_item(t, 0);
    mk(t, cau_pkg::OP_MUL, -32768, -32768, -32768, 32767); send_item(t, 0);
  endtask

  task automatic test_random(int n);
    cau_pkg::in_t t;
    bit           bursty;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) bursty = ($urandom_range(3) == 0);
      t.op = ($urandom_range(15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
      t.a_real = rand_operand(); t.a_imag = rand_operand();
      t.b_real = rand_operand(); t.b_imag = rand_operand();
      send_item(t, rand_gap(bursty));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(950);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
